[design/dscan_pkg.sv]
// ----------------------------------------------------------------------------
// dscan_pkg
// Shared types and scaling constants for the four-digit display scanner.
// ----------------------------------------------------------------------------
package dscan_pkg;

  typedef enum logic [1:0] {
    MODE_LIGHT = 2'd0,
    MODE_TEMP  = 2'd1,
    MODE_ACCEL = 2'd2,
    MODE_KEEP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    POS_THOUSANDS = 2'd0,
    POS_HUNDREDS  = 2'd1,
    POS_TENS      = 2'd2,
    POS_ONES      = 2'd3
  } pos_t;

  typedef logic [3:0] digit_t;

  localparam int unsigned TICK_W  = 10;
  localparam int unsigned VALUE_W = 14;

  localparam logic [TICK_W-1:0]  REFRESH_RESET = 10'd100;
  localparam logic [VALUE_W-1:0] VALUE_MAX     = 14'd9999;

  // light: x * 3300 / 4095 == x * 220 / 273, reciprocal scaled by 2^29
  localparam logic [40:0] LIGHT_MUL   = 41'd432643420;
  localparam int unsigned LIGHT_SHIFT = 29;

  // temperature: raw * 25 / 4
  localparam logic [20:0] TEMP_MUL = 21'd25;

  // acceleration: |3470 * z - 420750| / 255, reciprocal scaled by 2^27
  localparam logic [19:0] ACCEL_SCALE  = 20'd3470;
  localparam logic [19:0] ACCEL_OFFSET = 20'd420750;
  localparam logic [38:0] ACCEL_MUL    = 39'd526345;

  // decimal split reciprocals for values up to 9999
  localparam logic [27:0] DIV1000_MUL = 28'd16778;
  localparam logic [27:0] DIV100_MUL  = 28'd20972;
  localparam logic [27:0] DIV10_MUL   = 28'd26215;

  typedef struct packed {
    logic [11:0] light_q;
    logic [20:0] temp_x25;
    logic [18:0] accel_mag;
    mode_t       mode;
  } scaled_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               pt_th;
    logic               pt_hu;
    logic               keep;
  } latch_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [3:0]         q1000;
    logic [6:0]         q100;
    logic [9:0]         q10;
    logic               pt_th;
    logic               pt_hu;
    logic               keep;
  } quot_t;

  typedef struct packed {
    digit_t [3:0] digits;
    logic         pt_th;
    logic         pt_hu;
    logic         keep;
  } split_t;

endpackage

[design/dscan_in_if.sv]
// ----------------------------------------------------------------------------
// dscan_in_if
// Scan tick channel: display mode and raw sensor readings.
// ----------------------------------------------------------------------------
interface dscan_in_if;
  logic              valid;
  logic              ready;
  dscan_pkg::mode_t  mode;
  logic [11:0]       light_sample;
  logic [15:0]       temperature_raw;
  logic [7:0]        accel_raw;

  modport source (
    output valid, mode, light_sample, temperature_raw, accel_raw,
    input  ready
  );

  modport sink (
    input  valid, mode, light_sample, temperature_raw, accel_raw,
    output ready
  );
endinterface

[design/dscan_out_if.sv]
// ----------------------------------------------------------------------------
// dscan_out_if
// Display channel: digit, position, common lines and decimal point.
// ----------------------------------------------------------------------------
interface dscan_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit_value;
  logic [1:0] digit_position;
  logic [3:0] common_lines;
  logic       decimal_point;

  modport source (
    output valid, digit_value, digit_position, common_lines, decimal_point,
    input  ready
  );

  modport sink (
    input  valid, digit_value, digit_position, common_lines, decimal_point,
    output ready
  );
endinterface

[design/multiplexed_four_digit_display_scan.sv]
// A beat passes the input register, s2 to s5 and the output register.
// Throughput: one beat per cycle; the whole pipe stalls only while the
// display beat waits to be taken.
// Reset: synchronous, clears the pipe, tick counter, scan position, shown
// digits and points; refresh_ticks returns to 100.
// ----------------------------------------------------------------------------
// multiplexed_four_digit_display_scan
// Scales the selected sensor reading, splits it into decimal digits and scans
// the four digits with a refresh counter that relatches the shown value.
// ----------------------------------------------------------------------------
module multiplexed_four_digit_display_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dscan_pkg::TICK_W-1:0]  cfg_data,
  dscan_in_if.sink                      sample,
  dscan_out_if.source                   display
);

  logic en;

  // input register
  logic                 s1_valid;
  dscan_pkg::mode_t     s1_mode;
  logic [11:0]          s1_light;
  logic [15:0]          s1_temp;
  logic [7:0]           s1_accel;

  logic                 s2_valid;
  dscan_pkg::scaled_t   s2;
  dscan_pkg::scaled_t   s2_next;
  logic                 s3_valid;
  dscan_pkg::latch_t    s3;
  dscan_pkg::latch_t    s3_next;
  logic                 s4_valid;
  dscan_pkg::quot_t     s4;
  dscan_pkg::quot_t     s4_next;
  logic                 s5_valid;
  dscan_pkg::split_t    s5;
  dscan_pkg::split_t    s5_next;

  logic [40:0]          light_prod;
  logic [19:0]          accel_prod;
  logic [19:0]          accel_diff;
  logic [38:0]          accel_qprod;
  logic [18:0]          temp_val;
  logic [27:0]          p1000;
  logic [27:0]          p100;
  logic [27:0]          p10;
  logic [6:0]           q1000_x10;
  logic [9:0]           q100_x10;
  logic [13:0]          q10_x10;
  logic [6:0]           hu_full;
  logic [9:0]           te_full;
  logic [13:0]          on_full;

  // scan state
  logic [dscan_pkg::TICK_W-1:0] refresh_ticks;
  logic [dscan_pkg::TICK_W-1:0] tick_count;
  logic [dscan_pkg::TICK_W-1:0] tick_count_next;
  logic [1:0]                   position;
  logic [1:0]                   position_next;
  dscan_pkg::digit_t [3:0]      shown;
  dscan_pkg::digit_t [3:0]      shown_next;
  logic                         pt_th;
  logic                         pt_th_next;
  logic                         pt_hu;
  logic                         pt_hu_next;
  logic [dscan_pkg::TICK_W:0]   tick_inc;
  logic                         relatch;
  logic                         step;

  logic                 out_valid;
  logic [3:0]           out_digit;
  logic [3:0]           out_digit_next;
  logic [1:0]           out_pos;
  logic [3:0]           out_common;
  logic [3:0]           out_common_next;
  logic                 out_dp;
  logic                 out_dp_next;

  assign en           = !out_valid || display.ready;
  assign sample.ready = en;
  assign step         = en && s5_valid;

  // stage 1: constant products
  always_comb begin
    light_prod = 41'(s1_light) * dscan_pkg::LIGHT_MUL;
    accel_prod = 20'(s1_accel) * dscan_pkg::ACCEL_SCALE;
    if (accel_prod >= dscan_pkg::ACCEL_OFFSET) begin
      accel_diff = accel_prod - dscan_pkg::ACCEL_OFFSET;
    end else begin
      accel_diff = dscan_pkg::ACCEL_OFFSET - accel_prod;
    end
    s2_next.light_q   = light_prod[dscan_pkg::LIGHT_SHIFT +: 12];
    s2_next.temp_x25  = 21'(s1_temp) * dscan_pkg::TEMP_MUL;
    s2_next.accel_mag = accel_diff[18:0];
    s2_next.mode      = s1_mode;
  end

  // stage 2: divide, saturate, select by mode
  always_comb begin
    accel_qprod = 39'(s2.accel_mag) * dscan_pkg::ACCEL_MUL;
    temp_val    = s2.temp_x25[20:2];
    s3_next     = '0;
    case (s2.mode)
      dscan_pkg::MODE_LIGHT: begin
        s3_next.value = {2'b00, s2.light_q};
      end
      dscan_pkg::MODE_TEMP: begin
        s3_next.value = (temp_val > 19'(dscan_pkg::VALUE_MAX)) ?
                        dscan_pkg::VALUE_MAX : temp_val[13:0];
        s3_next.pt_hu = 1'b1;
      end
      dscan_pkg::MODE_ACCEL: begin
        s3_next.value = {3'b000, accel_qprod[37:27]};
        s3_next.pt_th = 1'b1;
      end
      default: begin
        s3_next.keep = 1'b1;
      end
    endcase
  end

  // stage 3: decimal quotients
  always_comb begin
    p1000 = 28'(s3.value) * dscan_pkg::DIV1000_MUL;
    p100  = 28'(s3.value) * dscan_pkg::DIV100_MUL;
    p10   = 28'(s3.value) * dscan_pkg::DIV10_MUL;
    s4_next.value = s3.value;
    s4_next.q1000 = p1000[27:24];
    s4_next.q100  = p100[27:21];
    s4_next.q10   = p10[27:18];
    s4_next.pt_th = s3.pt_th;
    s4_next.pt_hu = s3.pt_hu;
    s4_next.keep  = s3.keep;
  end

  // stage 4: digits
  always_comb begin
    q1000_x10 = {s4.q1000, 3'b000} + {2'b00, s4.q1000, 1'b0};
    q100_x10  = {s4.q100, 3'b000} + {2'b00, s4.q100, 1'b0};
    q10_x10   = {1'b0, s4.q10, 3'b000} + {3'b000, s4.q10, 1'b0};
    hu_full   = s4.q100 - q1000_x10;
    te_full   = s4.q10 - q100_x10;
    on_full   = s4.value - q10_x10;
    s5_next.digits[dscan_pkg::POS_THOUSANDS] = s4.q1000;
    s5_next.digits[dscan_pkg::POS_HUNDREDS]  = hu_full[3:0];
    s5_next.digits[dscan_pkg::POS_TENS]      = te_full[3:0];
    s5_next.digits[dscan_pkg::POS_ONES]      = on_full[3:0];
    s5_next.pt_th = s4.pt_th;
    s5_next.pt_hu = s4.pt_hu;
    s5_next.keep  = s4.keep;
  end

  // stage 5: refresh counter, latch and scan
  always_comb begin
    tick_inc      = {1'b0, tick_count} + 11'd1;
    relatch       = tick_inc >= {1'b0, refresh_ticks};
    position_next = position + 2'd1;
    shown_next    = shown;
    pt_th_next    = pt_th;
    pt_hu_next    = pt_hu;
    if (relatch) begin
      tick_count_next = '0;
      if (!s5.keep) begin
        shown_next = s5.digits;
        pt_th_next = s5.pt_th;
        pt_hu_next = s5.pt_hu;
      end
    end else begin
      tick_count_next = tick_inc[dscan_pkg::TICK_W-1:0];
    end
    out_digit_next  = shown_next[position_next];
    out_common_next = ~(4'b0001 << position_next);
    case (position_next)
      dscan_pkg::POS_THOUSANDS: out_dp_next = pt_th_next;
      dscan_pkg::POS_HUNDREDS:  out_dp_next = pt_hu_next;
      default:                  out_dp_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_ticks <= dscan_pkg::REFRESH_RESET;
    end else if (cfg_we) begin
      refresh_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= sample.valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      out_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode  <= sample.mode;
      s1_light <= sample.light_sample;
      s1_temp  <= sample.temperature_raw;
      s1_accel <= sample.accel_raw;
      s2       <= s2_next;
      s3       <= s3_next;
      s4       <= s4_next;
      s5       <= s5_next;
    end
    if (step) begin
      out_digit  <= out_digit_next;
      out_pos    <= position_next;
      out_common <= out_common_next;
      out_dp     <= out_dp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      position   <= '0;
      shown      <= '0;
      pt_th      <= 1'b0;
      pt_hu      <= 1'b0;
    end else if (step) begin
      tick_count <= tick_count_next;
      position   <= position_next;
      shown      <= shown_next;
      pt_th      <= pt_th_next;
      pt_hu      <= pt_hu_next;
    end
  end

  assign display.valid          = out_valid;
  assign display.digit_value    = out_digit;
  assign display.digit_position = out_pos;
  assign display.common_lines   = out_common;
  assign display.decimal_point  = out_dp;

`ifndef ASSERT_OFF
  // scan advances by one position per produced beat
  a_scan_step: assert property (@(posedge clk) disable iff (rst)
    step |=> position == $past(position) + 2'd1)
    else $error("scan position did not advance");

  // shown position tracks the scan register
  a_pos_track: assert property (@(posedge clk) disable iff (rst)
    step |=> display.digit_position == position)
    else $error("display position out of step with scan");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    display.valid |-> display.digit_value <= 4'd9)
    else $error("digit out of decimal range");

  a_common_onehot: assert property (@(posedge clk) disable iff (rst)
    display.valid |-> display.common_lines == ~(4'b0001 << display.digit_position))
    else $error("common lines do not match position");

  a_no_low_point: assert property (@(posedge clk) disable iff (rst)
    (display.valid && display.digit_position[1]) |-> !display.decimal_point)
    else $error("decimal point lit at tens or ones");
`endif

endmodule

[verif/display_scan_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_scan_checker
// Watches the scan tick and display channels of the four-digit display
// scanner, keeps its own copy of the refresh counter, scan position and
// latched value, predicts the display beat for every accepted tick and
// compares it field by field with the beats that leave the block.
// ----------------------------------------------------------------------------
module display_scan_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [dscan_pkg::TICK_W-1:0] cfg_data,
  dscan_in_if                         sample,
  dscan_out_if                        display,
  output int                          errors,
  output int                          pending
);

  typedef struct packed {
    dscan_pkg::digit_t digit;
    dscan_pkg::pos_t   pos;
    logic [3:0]        common;
    logic              point;
  } glyph_t;

  logic [dscan_pkg::TICK_W-1:0]  refresh_reg;
  logic [dscan_pkg::TICK_W-1:0]  tick_cnt;
  dscan_pkg::pos_t               scan_pos;
  logic [dscan_pkg::VALUE_W-1:0] held_value;
  logic                          dp_thousands;
  logic                          dp_hundreds;
  glyph_t                        glyph_q[$];

  assign pending = glyph_q.size();

  function automatic glyph_t scan_tick(input dscan_pkg::mode_t m, input logic [11:0] lt,
                                       input logic [15:0] tr, input logic [7:0] ar);
    logic [dscan_pkg::TICK_W:0] nxt;
    int unsigned                scaled;
    int unsigned                prod;
    glyph_t                     g;
    nxt = {1'b0, tick_cnt} + 1'b1;
    if (nxt >= {1'b0, refresh_reg}) begin
      tick_cnt = '0;
      if (m != dscan_pkg::MODE_KEEP) begin
        case (m)
          dscan_pkg::MODE_LIGHT: begin
            scaled = int'(lt) * 3300 / 4095;
            dp_thousands = 1'b0;
            dp_hundreds  = 1'b0;
          end
          dscan_pkg::MODE_TEMP: begin
            scaled = int'(tr) * 25 / 4;
            dp_thousands = 1'b0;
            dp_hundreds  = 1'b1;
          end
          default: begin
            prod = 3470 * int'(ar);
            scaled = (prod >= 420750) ? (prod - 420750) / 255 : (420750 - prod) / 255;
            dp_thousands = 1'b1;
            dp_hundreds  = 1'b0;
          end
        endcase
        held_value = (scaled > int'(dscan_pkg::VALUE_MAX)) ? dscan_pkg::VALUE_MAX :
                     scaled[dscan_pkg::VALUE_W-1:0];
      end
    end else begin
      tick_cnt = nxt[dscan_pkg::TICK_W-1:0];
    end
    scan_pos = dscan_pkg::pos_t'(scan_pos + 2'd1);
    g.pos    = scan_pos;
    g.common = ~(4'b0001 << scan_pos);
    case (scan_pos)
      dscan_pkg::POS_THOUSANDS: begin
        g.digit = 4'(held_value / 1000);
        g.point = dp_thousands;
      end
      dscan_pkg::POS_HUNDREDS: begin
        g.digit = 4'((held_value / 100) % 10);
        g.point = dp_hundreds;
      end
      dscan_pkg::POS_TENS: begin
        g.digit = 4'((held_value / 10) % 10);
        g.point = 1'b0;
      end
      default: begin
        g.digit = 4'(held_value % 10);
        g.point = 1'b0;
      end
    endcase
    return g;
  endfunction

  task automatic report(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    glyph_t want;
    if (rst) begin
      refresh_reg  = dscan_pkg::REFRESH_RESET;
      tick_cnt     = '0;
      scan_pos     = dscan_pkg::POS_THOUSANDS;
      held_value   = '0;
      dp_thousands = 1'b0;
      dp_hundreds  = 1'b0;
      glyph_q.delete();
    end else begin
      if (cfg_we) begin
        refresh_reg = cfg_data;
      end
      if (sample.valid && sample.ready) begin
        glyph_q.push_back(scan_tick(sample.mode, sample.light_sample,
                                    sample.temperature_raw, sample.accel_raw));
      end
      if (display.valid && display.ready) begin
        if (glyph_q.size() == 0) begin
          errors++;
          $display("%0t: display beat with nothing expected, actual digit %0d position %0d",
                   $time, display.digit_value, display.digit_position);
        end else begin
          want = glyph_q.pop_front();
          report("digit_value", want.digit, display.digit_value);
          report("digit_position", want.pos, display.digit_position);
          report("common_lines", want.common, display.common_lines);
          report("decimal_point", want.point, display.decimal_point);
        end
      end
    end
  end

endmodule

[verif/tb_multiplexed_four_digit_display_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiplexed_four_digit_display_scan
// Drives scan ticks into the display scanner with random gaps and display
// stalls, steps the refresh count through its extremes between phases and
// lets the checker predict and compare every display beat.
// ----------------------------------------------------------------------------
module tb_multiplexed_four_digit_display_scan;

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [dscan_pkg::TICK_W-1:0] cfg_data;
  bit                           gaps_on;
  int                           check_errors;
  int                           pending_beats;

  logic [dscan_pkg::TICK_W-1:0] phase_refresh[8] = '{10'd1, 10'd0, 10'd2, 10'd1023,
                                                     10'd4, 10'd3, 10'd7, 10'd1};
  int                           phase_items[8]   = '{70, 40, 60, 50, 60, 60, 60, 50};

  dscan_in_if  sample_ch();
  dscan_out_if display_ch();

  multiplexed_four_digit_display_scan dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .sample   (sample_ch),
    .display  (display_ch)
  );

  display_scan_checker chk (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .sample   (sample_ch),
    .display  (display_ch),
    .errors   (check_errors),
    .pending  (pending_beats)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_tick(input dscan_pkg::mode_t m, input logic [11:0] lt,
                           input logic [15:0] tr, input logic [7:0] ar);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid           <= 1'b1;
    sample_ch.mode            <= m;
    sample_ch.light_sample    <= lt;
    sample_ch.temperature_raw <= tr;
    sample_ch.accel_raw       <= ar;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid and let every outstanding display beat drain
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    while (pending_beats != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_refresh(input logic [dscan_pkg::TICK_W-1:0] value);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  // display side back-pressure
  initial begin
    int stall;
    stall = 0;
    display_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        display_ch.ready <= 1'b0;
        stall--;
      end else begin
        display_ch.ready <= 1'b1;
        if (gaps_on && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin
    dscan_pkg::mode_t m;
    logic [11:0]      lt;
    logic [15:0]      tr;
    rst                       = 1'b1;
    cfg_we                    = 1'b0;
    cfg_data                  = '0;
    gaps_on                   = 1'b1;
    sample_ch.valid           = 1'b0;
    sample_ch.mode            = dscan_pkg::MODE_LIGHT;
    sample_ch.light_sample    = '0;
    sample_ch.temperature_raw = '0;
    sample_ch.accel_raw       = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default refresh count, nothing latched yet
    send_tick(dscan_pkg::MODE_LIGHT, 12'hFFF, 16'hFFFF, 8'hFF);
    send_tick(dscan_pkg::MODE_TEMP, 12'h000, 16'h0000, 8'h00);
    send_tick(dscan_pkg::MODE_ACCEL, 12'h555, 16'h5555, 8'h55);

    // latch on every tick
    write_refresh(10'd1);
    send_tick(dscan_pkg::MODE_LIGHT, 12'h000, 16'hFFFF, 8'hFF);
    send_tick(dscan_pkg::MODE_LIGHT, 12'hFFF, 16'h0000, 8'h00);
    send_tick(dscan_pkg::MODE_LIGHT, 12'h800, 16'h0000, 8'h00);
    send_tick(dscan_pkg::MODE_LIGHT, 12'hFFF, 16'h0000, 8'h00);
    send_tick(dscan_pkg::MODE_TEMP, 12'hFFF, 16'h0000, 8'hFF);
    send_tick(dscan_pkg::MODE_TEMP, 12'h000, 16'hFFFF, 8'h00);
    send_tick(dscan_pkg::MODE_TEMP, 12'h000, 16'd1599, 8'h00);
    send_tick(dscan_pkg::MODE_TEMP, 12'h000, 16'd1600, 8'h00);
    send_tick(dscan_pkg::MODE_ACCEL, 12'h000, 16'h0000, 8'h00);
    send_tick(dscan_pkg::MODE_ACCEL, 12'hFFF, 16'hFFFF, 8'hFF);
    send_tick(dscan_pkg::MODE_ACCEL, 12'h000, 16'h0000, 8'd121);
    send_tick(dscan_pkg::MODE_ACCEL, 12'h000, 16'h0000, 8'd122);
    send_tick(dscan_pkg::MODE_KEEP, 12'hFFF, 16'hFFFF, 8'hFF);
    send_tick(dscan_pkg::MODE_KEEP, 12'h000, 16'h0000, 8'h00);
    send_tick(dscan_pkg::MODE_KEEP, 12'h123, 16'h4567, 8'h89);

    // zero refresh count still latches every tick
    write_refresh(10'd0);
    send_tick(dscan_pkg::MODE_LIGHT, 12'd1234, 16'h0000, 8'h00);
    send_tick(dscan_pkg::MODE_KEEP, 12'h000, 16'h0000, 8'h00);
    send_tick(dscan_pkg::MODE_TEMP, 12'h000, 16'd100, 8'h00);
    send_tick(dscan_pkg::MODE_ACCEL, 12'h000, 16'h0000, 8'd200);

    for (int p = 0; p < 8; p++) begin
      write_refresh(phase_refresh[p]);
      gaps_on = (p % 3 != 1);
      for (int i = 0; i < phase_items[p]; i++) begin
        if (p == 2 && i == 30) wait_idle();
        m  = ($urandom_range(0, 99) < 15) ? dscan_pkg::MODE_KEEP :
             dscan_pkg::mode_t'($urandom_range(0, 2));
        lt = ($urandom_range(0, 9) == 0) ? {12{1'($urandom_range(0, 1))}} : 12'($urandom);
        tr = $urandom_range(0, 1) ? 16'($urandom_range(0, 1700)) : 16'($urandom);
        send_tick(m, lt, tr, 8'($urandom));
      end
    end

    gaps_on = 1'b1;
    wait_idle();
    repeat (20) @(posedge clk);
    if (check_errors == 0 && pending_beats == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
